FILE: rtl/ssdr_pkg.sv
// ----------------------------------------------------------------------------
// ssdr_pkg
// Shared types, constants and functions of the seven-segment digit reader:
// probe layout, controller commands and the digit decision tree.
// ----------------------------------------------------------------------------
package ssdr_pkg;

  localparam int PROBE_COUNT = 32;
  localparam int PROBE_IDX_W = 5;
  localparam int COORD_W     = 11;
  localparam int FLAG_COUNT  = 9;

  localparam logic [3:0] NO_MATCH = 4'd10;

  // Reciprocal multiply for a divide by three, exact for inputs below 1024
  localparam int DIV3_MUL   = 683;
  localparam int DIV3_SHIFT = 11;

  // Dark flag bit positions
  localparam logic [3:0] FLAG_LU  = 4'd0;
  localparam logic [3:0] FLAG_RU  = 4'd1;
  localparam logic [3:0] FLAG_MD  = 4'd2;
  localparam logic [3:0] FLAG_MM  = 4'd3;
  localparam logic [3:0] FLAG_MQU = 4'd4;
  localparam logic [3:0] FLAG_MQD = 4'd5;
  localparam logic [3:0] FLAG_MU  = 4'd6;
  localparam logic [3:0] FLAG_RD  = 4'd7;
  localparam logic [3:0] FLAG_LD  = 4'd8;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [FLAG_COUNT-1:0]     flags_t;

  // Probe column base: box left, right edge, 2/3, 1/2 and 1/3 of the width
  typedef enum logic [2:0] {
    COL_X, COL_XW, COL_XW23, COL_XW2, COL_XW3
  } col_sel_e;

  // Probe row base: box top, bottom edge and fractions of the height
  typedef enum logic [2:0] {
    ROW_Y, ROW_YH, ROW_YH3, ROW_YH23, ROW_YH2, ROW_YH4, ROW_YH34
  } row_sel_e;

  typedef struct packed {
    col_sel_e           col_sel;
    row_sel_e           row_sel;
    logic signed [3:0]  col_off;
    logic signed [3:0]  row_off;
    logic [3:0]         flag;
  } probe_t;

  typedef struct packed {
    logic                   load_box;
    logic                   setup;
    logic                   probe_issue;
    logic [PROBE_IDX_W-1:0] probe_idx;
    logic                   write_pixel;
    logic                   load_out;
  } ssdr_cmd_t;

  typedef struct packed {
    logic pipe_busy;
  } ssdr_status_t;

  function automatic logic [8:0] div3(logic [9:0] n);
    logic [19:0] prod;
    prod = 20'(n) * 20'(DIV3_MUL);
    return 9'(prod >> DIV3_SHIFT);
  endfunction

  // Probe layout: segment runs in sweep order, offsets relative to the base
  function automatic probe_t probe_at(logic [PROBE_IDX_W-1:0] k);
    probe_t p;
    p.col_off = 4'sd0;
    p.row_off = 4'sd0;
    priority if (k < 5'd4) begin
      p.col_sel = COL_X;    p.row_sel = ROW_YH3;  p.col_off = 4'(k);
      p.flag = FLAG_LU;
    end else if (k < 5'd9) begin
      p.col_sel = COL_XW;   p.row_sel = ROW_YH3;  p.col_off = 4'(k - 5'd8);
      p.flag = FLAG_RU;
    end else if (k < 5'd11) begin
      p.col_sel = COL_XW23; p.row_sel = ROW_YH;   p.row_off = 4'(k - 5'd10);
      p.flag = FLAG_MD;
    end else if (k < 5'd16) begin
      p.col_sel = COL_XW2;  p.row_sel = ROW_YH2;  p.row_off = 4'(k - 5'd14);
      p.flag = FLAG_MM;
    end else if (k < 5'd19) begin
      p.col_sel = COL_XW2;  p.row_sel = ROW_YH4;  p.row_off = 4'(k - 5'd17);
      p.flag = FLAG_MQU;
    end else if (k < 5'd24) begin
      p.col_sel = COL_XW2;  p.row_sel = ROW_YH34; p.row_off = 4'(k - 5'd21);
      p.flag = FLAG_MQD;
    end else if (k < 5'd26) begin
      p.col_sel = COL_XW3;  p.row_sel = ROW_Y;    p.row_off = 4'(k - 5'd24);
      p.flag = FLAG_MU;
    end else if (k < 5'd29) begin
      p.col_sel = COL_XW;   p.row_sel = ROW_YH23; p.col_off = 4'(k - 5'd28);
      p.flag = FLAG_RD;
    end else begin
      p.col_sel = COL_X;    p.row_sel = ROW_YH23; p.col_off = 4'(k - 5'd29);
      p.flag = FLAG_LD;
    end
    return p;
  endfunction

  // Ordered decision tree, first matching rule wins
  function automatic logic [3:0] decide(flags_t f);
    logic lu, ru, md, mm, mqu, mqd, mu, rd, ld;
    logic [3:0] d;
    lu  = f[FLAG_LU];  ru  = f[FLAG_RU];  md = f[FLAG_MD];
    mm  = f[FLAG_MM];  mqu = f[FLAG_MQU]; mqd = f[FLAG_MQD];
    mu  = f[FLAG_MU];  rd  = f[FLAG_RD];  ld = f[FLAG_LD];
    d = NO_MATCH;
    priority if (mqu && !mm && !mqd && ru && !mu && rd) d = 4'd1;
    else if (!mqu && !mm && !mqd && ru && lu && mu) d = 4'd0;
    else if (mqd && !rd && ru && !lu && !md && mu) d = 4'd7;
    else if (mqd && !rd && !mqu && ru && md && !lu && mu) d = 4'd2;
    else if (!mqu && mm && mqd && ru && lu && !md && mu) d = 4'd9;
    else if (mm && mqd && ru && !mu && ld && !lu) d = 4'd4;
    else if (mm && !mqd && md && !mu && mqu && ld) d = 4'd6;
    else if (mm && !mqd && md && mu && !lu && !ld && rd) d = 4'd3;
    else if (mm && mu && md && !ru && lu) d = 4'd5;
    else if (mm && mu && md && ru && lu && !mqd) d = 4'd8;
    else d = NO_MATCH;
    return d;
  endfunction

endpackage

FILE: rtl/ssdr_ctrl.sv
// ----------------------------------------------------------------------------
// ssdr_ctrl
// Controller: accepts items, sequences the probe sweep and owns the result
// valid flag.
// ----------------------------------------------------------------------------
module ssdr_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_op_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  ssdr_pkg::ssdr_status_t status_i,
  output ssdr_pkg::ssdr_cmd_t  cmd_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SETUP  = 3'd1;
  localparam logic [2:0] ST_SWEEP  = 3'd2;
  localparam logic [2:0] ST_DRAIN  = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  localparam logic OP_WRITE = 1'b0;
  localparam logic [ssdr_pkg::PROBE_IDX_W-1:0] LAST_PROBE =
    ssdr_pkg::PROBE_IDX_W'(ssdr_pkg::PROBE_COUNT - 1);

  logic [2:0]                       state_q, state_d;
  logic [ssdr_pkg::PROBE_IDX_W-1:0] idx_q, idx_d;
  logic                             out_valid_q, out_valid_d;
  logic                             accept;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d           = state_q;
    idx_d             = idx_q;
    cmd_o             = '0;
    cmd_o.probe_idx   = idx_q;
    out_valid_d       = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_op_i == OP_WRITE) begin
            cmd_o.write_pixel = 1'b1;
          end else begin
            cmd_o.load_box = 1'b1;
            state_d        = ST_SETUP;
          end
        end
      end
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
        idx_d       = '0;
        state_d     = ST_SWEEP;
      end
      ST_SWEEP: begin
        cmd_o.probe_issue = 1'b1;
        idx_d             = idx_q + 1'b1;
        if (idx_q == LAST_PROBE) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status_i.pipe_busy) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: rtl/ssdr_datapath.sv
// ----------------------------------------------------------------------------
// ssdr_datapath
// Datapath: frame store, box geometry, probe address pipeline, dark flag
// accumulation and result register.
// ----------------------------------------------------------------------------
module ssdr_datapath #(
  parameter int FRAME_WIDTH  = 256,
  parameter int FRAME_HEIGHT = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ssdr_pkg::ssdr_cmd_t   cmd_i,
  output ssdr_pkg::ssdr_status_t status_o,
  input  logic                  cfg_we_i,
  input  logic [7:0]            cfg_data_i,
  input  logic [7:0]            pixel_x_i,
  input  logic [7:0]            pixel_y_i,
  input  logic [7:0]            pixel_value_i,
  input  logic [7:0]            box_x_i,
  input  logic [7:0]            box_y_i,
  input  logic [8:0]            box_width_i,
  input  logic [8:0]            box_height_i,
  output logic [3:0]            digit_o,
  output logic [8:0]            probe_flags_o
);

  localparam int DEPTH  = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);

  logic [7:0] frame_mem [DEPTH];

  logic [7:0] white_level_q;
  logic [7:0] box_x_q, box_y_q;
  logic [8:0] box_w_q, box_h_q;

  ssdr_pkg::coord_t cx_q, cxw_q, cxw23_q, cxw2_q, cxw3_q;
  ssdr_pkg::coord_t ry_q, ryh_q, ryh3_q, ryh23_q, ryh2_q, ryh4_q, ryh34_q;

  ssdr_pkg::probe_t probe;
  ssdr_pkg::coord_t col_base, row_base, col_a_d, row_a_d;
  ssdr_pkg::coord_t col_a_q, row_a_q;
  logic [3:0]       flag_a_q, flag_b_q, flag_c_q;
  logic             a_valid_q, b_valid_q, c_valid_q;
  logic             inside_b_d, inside_b_q, inside_c_q;
  logic [ADDR_W-1:0] addr_b_d, addr_b_q;
  logic [7:0]       rd_data_q;
  ssdr_pkg::flags_t flags_q;
  logic [3:0]       digit_q;
  logic [8:0]       out_flags_q;

  logic              wr_inside;
  logic [ADDR_W-1:0] wr_addr;

  assign status_o.pipe_busy = a_valid_q || b_valid_q || c_valid_q;

  // White level register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      white_level_q <= 8'd255;
    end else if (cfg_we_i) begin
      white_level_q <= cfg_data_i;
    end
  end

  // Box capture and geometry
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_box) begin
      box_x_q <= box_x_i;
      box_y_q <= box_y_i;
      box_w_q <= box_width_i;
      box_h_q <= box_height_i;
    end
    if (cmd_i.setup) begin
      cx_q    <= ssdr_pkg::coord_t'(box_x_q);
      cxw_q   <= ssdr_pkg::coord_t'(box_x_q) + ssdr_pkg::coord_t'(box_w_q);
      cxw23_q <= ssdr_pkg::coord_t'(box_x_q)
                 + ssdr_pkg::coord_t'(ssdr_pkg::div3({box_w_q, 1'b0}));
      cxw2_q  <= ssdr_pkg::coord_t'(box_x_q) + ssdr_pkg::coord_t'(box_w_q >> 1);
      cxw3_q  <= ssdr_pkg::coord_t'(box_x_q)
                 + ssdr_pkg::coord_t'(ssdr_pkg::div3({1'b0, box_w_q}));
      ry_q    <= ssdr_pkg::coord_t'(box_y_q);
      ryh_q   <= ssdr_pkg::coord_t'(box_y_q) + ssdr_pkg::coord_t'(box_h_q);
      ryh3_q  <= ssdr_pkg::coord_t'(box_y_q)
                 + ssdr_pkg::coord_t'(ssdr_pkg::div3({1'b0, box_h_q}));
      ryh23_q <= ssdr_pkg::coord_t'(box_y_q)
                 + ssdr_pkg::coord_t'(ssdr_pkg::div3({box_h_q, 1'b0}));
      ryh2_q  <= ssdr_pkg::coord_t'(box_y_q) + ssdr_pkg::coord_t'(box_h_q >> 1);
      ryh4_q  <= ssdr_pkg::coord_t'(box_y_q) + ssdr_pkg::coord_t'(box_h_q >> 2);
      ryh34_q <= ssdr_pkg::coord_t'(box_y_q)
                 + ssdr_pkg::coord_t'((11'(box_h_q) * 11'd3) >> 2);
    end
  end

  // Stage A: probe coordinates
  always_comb begin
    probe = ssdr_pkg::probe_at(cmd_i.probe_idx);
    unique case (probe.col_sel)
      ssdr_pkg::COL_X:    col_base = cx_q;
      ssdr_pkg::COL_XW:   col_base = cxw_q;
      ssdr_pkg::COL_XW23: col_base = cxw23_q;
      ssdr_pkg::COL_XW2:  col_base = cxw2_q;
      ssdr_pkg::COL_XW3:  col_base = cxw3_q;
      default:            col_base = cx_q;
    endcase
    unique case (probe.row_sel)
      ssdr_pkg::ROW_Y:    row_base = ry_q;
      ssdr_pkg::ROW_YH:   row_base = ryh_q;
      ssdr_pkg::ROW_YH3:  row_base = ryh3_q;
      ssdr_pkg::ROW_YH23: row_base = ryh23_q;
      ssdr_pkg::ROW_YH2:  row_base = ryh2_q;
      ssdr_pkg::ROW_YH4:  row_base = ryh4_q;
      ssdr_pkg::ROW_YH34: row_base = ryh34_q;
      default:            row_base = ry_q;
    endcase
    col_a_d = col_base + ssdr_pkg::coord_t'(probe.col_off);
    row_a_d = row_base + ssdr_pkg::coord_t'(probe.row_off);
  end

  // Stage B: frame bounds and read address
  always_comb begin
    inside_b_d = !col_a_q[ssdr_pkg::COORD_W-1] && !row_a_q[ssdr_pkg::COORD_W-1]
                 && (32'(col_a_q[ssdr_pkg::COORD_W-2:0]) < FRAME_WIDTH)
                 && (32'(row_a_q[ssdr_pkg::COORD_W-2:0]) < FRAME_HEIGHT);
    addr_b_d   = ADDR_W'(32'(row_a_q[ssdr_pkg::COORD_W-2:0]) * FRAME_WIDTH
                         + 32'(col_a_q[ssdr_pkg::COORD_W-2:0]));
  end

  // Pixel write address; drop writes outside the frame
  assign wr_inside = (32'(pixel_x_i) < FRAME_WIDTH) && (32'(pixel_y_i) < FRAME_HEIGHT);
  assign wr_addr   = ADDR_W'(32'(pixel_y_i) * FRAME_WIDTH + 32'(pixel_x_i));

  // Stage C: frame store
  always_ff @(posedge clk_i) begin
    if (cmd_i.write_pixel && wr_inside) begin
      frame_mem[wr_addr] <= pixel_value_i;
    end
    rd_data_q <= frame_mem[addr_b_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      a_valid_q <= cmd_i.probe_issue;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    col_a_q    <= col_a_d;
    row_a_q    <= row_a_d;
    flag_a_q   <= probe.flag;
    addr_b_q   <= addr_b_d;
    inside_b_q <= inside_b_d;
    flag_b_q   <= flag_a_q;
    inside_c_q <= inside_b_q;
    flag_c_q   <= flag_b_q;
  end

  // Stage D: accumulate dark flags
  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      flags_q <= '0;
    end else if (c_valid_q && inside_c_q && (rd_data_q < white_level_q)) begin
      flags_q[flag_c_q] <= 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      digit_q     <= ssdr_pkg::decide(flags_q);
      out_flags_q <= flags_q;
    end
  end

  assign digit_o       = digit_q;
  assign probe_flags_o = out_flags_q;

endmodule

FILE: rtl/seven_segment_digit_reader.sv
// ----------------------------------------------------------------------------
// seven_segment_digit_reader
// Reads a seven-segment digit out of a stored grayscale frame by sampling
// 32 probe pixels inside a digit box and running a decision tree.
// ----------------------------------------------------------------------------
// A write item (tuser 0) stores one pixel; writes outside the frame are
// dropped and give no result. A recognize item (tuser 1) is accepted, the
// box fractions are worked out, the 32 probe reads are issued in turn, each
// passes the address, memory and compare stages, the probe pipeline is seen
// to empty, and the result is loaded. Probes outside the frame count as
// white. The frame store has no reset: recognize a box only over pixels
// already written. The result register lets a new item be accepted while
// a result still waits; a second recognize holds in its final cycle until
// that result is taken. white_level resets to 255 and is written through
// the cfg channel; the user must write it only while idle, as the block
// does not enforce this.
module seven_segment_digit_reader #(
  parameter int FRAME_WIDTH  = 256,
  parameter int FRAME_HEIGHT = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input items
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // pixel_x[7:0], pixel_y[15:8], pixel_value[23:16], box_x[31:24],
  // box_y[39:32], box_width[48:40], box_height[57:49], zero fill [63:58]
  input  logic [63:0] s_axis_tdata_i,
  // op[0]: 0 writes a pixel, 1 recognizes a box
  input  logic        s_axis_tuser_i,
  // Result items
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // digit[3:0], probe_flags[12:4], zero fill [15:13]
  output logic [15:0] m_axis_tdata_o,
  // white_level write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i
);

  ssdr_pkg::ssdr_cmd_t    cmd;
  ssdr_pkg::ssdr_status_t status;
  logic [3:0]             digit;
  logic [8:0]             probe_flags;

  // Configuration writes are always taken
  assign cfg_ready_o = 1'b1;

  ssdr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_op_i     (s_axis_tuser_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  ssdr_datapath #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .pixel_x_i     (s_axis_tdata_i[7:0]),
    .pixel_y_i     (s_axis_tdata_i[15:8]),
    .pixel_value_i (s_axis_tdata_i[23:16]),
    .box_x_i       (s_axis_tdata_i[31:24]),
    .box_y_i       (s_axis_tdata_i[39:32]),
    .box_width_i   (s_axis_tdata_i[48:40]),
    .box_height_i  (s_axis_tdata_i[57:49]),
    .digit_o       (digit),
    .probe_flags_o (probe_flags)
  );

  assign m_axis_tdata_o = {3'b000, probe_flags, digit};

  // No input item is taken while probes are in flight
  a_no_accept_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.probe_issue |-> !s_axis_tready_o)
    else $error("input accepted during probe sweep");

  // The result is loaded only once the probe pipeline has drained
  a_load_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> !status.pipe_busy)
    else $error("result loaded with probes still in flight");

  // A presented digit is 0 to 9 or the no-match code
  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[3:0] <= ssdr_pkg::NO_MATCH))
    else $error("digit out of range");

  // A pixel write never overlaps a recognize in progress
  a_write_idle_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.write_pixel |-> !status.pipe_busy && !cmd.load_out)
    else $error("pixel write during recognize");

endmodule
